// ===== hw/rtl/lpmr_pkg.sv =====
// Shared types, codes and constants of the length-prefixed message ring.
`default_nettype none

package lpmr_pkg;

    // Default sizing of the ring and of the largest message.
    localparam int C_RING_WORDS        = 256;
    localparam int C_MAX_MESSAGE_WORDS = 16;

    // Width used for byte-length comparisons; the largest message of 16 words is 64 bytes.
    localparam int C_LEN_W = 9;

    // Reset value of the maximum message length register.
    localparam logic [6:0] C_MAX_BYTES_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_DEACT = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_LONG = 3'd1,
        ST_NO_ROOM  = 3'd2,
        ST_INACTIVE = 3'd3,
        ST_LOCK     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR,
        S_RD_HDR,
        S_RD_DATA
    } t_ctl_state;

    typedef enum logic [1:0] {
        RUN_IDLE,
        RUN_WRITING,
        RUN_DISCARD
    } t_run_phase;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  message_bytes;
        logic [31:0] data_word;
        logic        last_word;
        logic        lock_denied;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] read_word;
        logic [6:0]  read_bytes;
        logic        last_result;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    run_start;
        logic    run_word;
        logic    wr_commit;
        logic    set_active;
        logic    hdr_write;
        logic    deact;
        logic    rd_start;
        logic    rd_hdr;
        logic    rd_next;
        logic    res_load;
        logic    res_data;
        t_status res_status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_status wr_check;
        logic    active;
        logic    empty;
        logic    rd_zero;
        logic    rd_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/lpmr_ctrl.sv =====
// Controller state machine of the message ring: sequencing, run phase and result valid.
`default_nettype none

module lpmr_ctrl import lpmr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_item_valid,
    output logic     o_item_ready,
    input  t_item    i_item,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd
);

    t_ctl_state r_state, n_state;
    t_run_phase r_phase, n_phase;
    logic       r_res_valid, n_res_valid;
    logic       w_slot_free;
    logic       w_fire;

    assign w_slot_free  = !r_res_valid || i_res_ready;
    assign o_item_ready = (r_state == S_IDLE) && w_slot_free;
    assign w_fire       = i_item_valid && o_item_ready;
    assign o_res_valid  = r_res_valid;

    // Next state and run phase.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    case (i_item.operation)
                        OP_WRITE: begin
                            case (r_phase)
                                RUN_DISCARD: begin
                                    if (i_item.last_word) n_phase = RUN_IDLE;
                                end
                                RUN_WRITING: begin
                                    if (i_item.last_word) n_phase = RUN_IDLE;
                                end
                                default: begin
                                    if (i_stat.wr_check != ST_OK) begin
                                        n_phase = i_item.last_word ? RUN_IDLE : RUN_DISCARD;
                                    end else begin
                                        n_phase = i_item.last_word ? RUN_IDLE : RUN_WRITING;
                                        n_state = S_HDR;
                                    end
                                end
                            endcase
                        end
                        OP_READ: begin
                            n_phase = RUN_IDLE;
                            if (!i_item.lock_denied && i_stat.active && !i_stat.empty)
                                n_state = S_RD_HDR;
                        end
                        OP_DEACT: begin
                            n_phase = RUN_IDLE;
                        end
                        default: ;
                    endcase
                end
            end
            S_HDR:     n_state = S_IDLE;
            S_RD_HDR:  n_state = i_stat.rd_zero ? S_IDLE : S_RD_DATA;
            S_RD_DATA: begin
                if (w_slot_free && i_stat.rd_last) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    case (i_item.operation)
                        OP_WRITE: begin
                            case (r_phase)
                                RUN_DISCARD: ;
                                RUN_WRITING: begin
                                    o_cmd.run_word = 1'b1;
                                    if (i_item.last_word) begin
                                        o_cmd.wr_commit = 1'b1;
                                        o_cmd.res_load  = 1'b1;
                                    end
                                end
                                default: begin
                                    if (i_stat.wr_check != ST_OK) begin
                                        o_cmd.res_load   = 1'b1;
                                        o_cmd.res_status = i_stat.wr_check;
                                        o_cmd.set_active = (i_stat.wr_check == ST_NO_ROOM);
                                    end else begin
                                        o_cmd.run_start = 1'b1;
                                        if (i_item.last_word) begin
                                            o_cmd.wr_commit = 1'b1;
                                            o_cmd.res_load  = 1'b1;
                                        end
                                    end
                                end
                            endcase
                        end
                        OP_READ: begin
                            if (i_item.lock_denied) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = ST_LOCK;
                            end else if (!i_stat.active) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = ST_INACTIVE;
                            end else if (i_stat.empty) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = ST_NO_ROOM;
                            end else begin
                                o_cmd.rd_start = 1'b1;
                            end
                        end
                        OP_DEACT: begin
                            o_cmd.res_load = 1'b1;
                            if (i_item.lock_denied) o_cmd.res_status = ST_LOCK;
                            else                    o_cmd.deact      = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_HDR: begin
                o_cmd.hdr_write = 1'b1;
            end
            S_RD_HDR: begin
                o_cmd.rd_hdr = 1'b1;
                if (i_stat.rd_zero) o_cmd.res_load = 1'b1;
            end
            S_RD_DATA: begin
                if (w_slot_free) begin
                    o_cmd.rd_next  = 1'b1;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_data = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign n_res_valid = o_cmd.res_load ? 1'b1 : (i_res_ready ? 1'b0 : r_res_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= RUN_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_res_valid <= n_res_valid;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lpmr_datapath.sv =====
// Datapath of the message ring: ring memory, pointers, counters and the result register.
`default_nettype none

module lpmr_datapath import lpmr_pkg::*; #(
    parameter int RING_WORDS        = C_RING_WORDS,
    parameter int MAX_MESSAGE_WORDS = C_MAX_MESSAGE_WORDS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  t_cmd       i_cmd,
    output t_dp_stat   o_stat,
    output t_res       o_res,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data
);

    localparam int IW        = $clog2(RING_WORDS);
    localparam int SW        = IW + 8;
    localparam int FW        = $clog2(RING_WORDS + 1);
    localparam int FSW       = FW + 8;
    localparam int CW        = (FW > 7) ? FW : 7;
    localparam int WCW       = $clog2(MAX_MESSAGE_WORDS + 1);
    localparam int MAX_BYTES = MAX_MESSAGE_WORDS * 4;

    // Index sums never exceed twice the ring size, so one subtraction wraps them.
    function automatic logic [IW-1:0] f_wrap(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= SW'(RING_WORDS)) ? s - SW'(RING_WORDS) : s;
        return t[IW-1:0];
    endfunction

    logic [31:0]    r_mem [RING_WORDS];
    logic [31:0]    r_rdata;
    logic [IW-1:0]  r_head, r_tail;
    logic [FW-1:0]  r_free;
    logic [FW-1:0]  r_count;
    logic           r_active;
    logic [6:0]     r_max;
    logic [IW-1:0]  r_wr_idx;
    logic [WCW-1:0] r_seen;
    logic [WCW-1:0] r_run_words;
    logic [IW-1:0]  r_hdr_addr;
    logic [7:0]     r_hdr_bytes;
    logic [IW-1:0]  r_rd_pos;
    logic [WCW-1:0] r_rd_left;
    logic [6:0]     r_rd_bytes;
    t_res           r_res;

    logic [C_LEN_W-1:0] w_len, w_lim;
    logic [8:0]         w_len_p3;
    logic [6:0]         w_words7;
    logic [CW-1:0]      w_need;
    logic [WCW-1:0]     w_words_now;
    logic [WCW-1:0]     w_eff_words;
    logic [IW-1:0]      w_wr_base;
    logic [WCW-1:0]     w_seen_base;
    logic               w_data_we;
    logic               w_mem_we;
    logic [IW-1:0]      w_mem_addr;
    logic [31:0]        w_mem_wdata;
    logic [31:0]        w_hdr_clip;
    logic [32:0]        w_hdr_p3;
    logic [WCW-1:0]     w_rd_n;
    logic               w_rd_zero;
    logic               w_rd_last;
    logic [IW-1:0]      w_head_p1;
    logic [IW-1:0]      w_rd_pos_p1;
    logic               w_rd_en;
    logic [IW-1:0]      w_rd_addr;
    logic [FSW-1:0]     w_free_sum;
    logic [FW-1:0]      w_free_rd;
    t_status            w_wr_check;

    // Checks on the first word of a write run: the length in bytes, the room in words.
    always_comb begin
        w_len    = C_LEN_W'(i_item.message_bytes);
        w_lim    = (C_LEN_W'(r_max) > C_LEN_W'(MAX_BYTES)) ? C_LEN_W'(MAX_BYTES)
                                                          : C_LEN_W'(r_max);
        w_len_p3 = {1'b0, i_item.message_bytes} + 9'd3;
        w_words7 = w_len_p3[8:2];
        w_need   = CW'(w_words7) + CW'(1);
        if (w_len > w_lim)                 w_wr_check = ST_TOO_LONG;
        else if (i_item.lock_denied)       w_wr_check = ST_LOCK;
        else if (w_need > CW'(r_free))     w_wr_check = ST_NO_ROOM;
        else                               w_wr_check = ST_OK;
    end

    assign w_words_now = WCW'(w_words7);
    assign w_eff_words = i_cmd.run_start ? w_words_now : r_run_words;
    assign w_wr_base   = i_cmd.run_start ? f_wrap(SW'(r_tail) + SW'(1)) : r_wr_idx;
    assign w_seen_base = i_cmd.run_start ? '0 : r_seen;
    assign w_data_we   = (i_cmd.run_start || i_cmd.run_word) && (w_seen_base < w_eff_words);

    // One write port, shared by data words and the deferred header.
    assign w_mem_we    = i_cmd.hdr_write || w_data_we;
    assign w_mem_addr  = i_cmd.hdr_write ? r_hdr_addr : w_wr_base;
    assign w_mem_wdata = i_cmd.hdr_write ? {24'd0, r_hdr_bytes} : i_item.data_word;

    // Header decoding on the registered read data.
    assign w_hdr_clip  = (r_rdata > 32'(MAX_BYTES)) ? 32'(MAX_BYTES) : r_rdata;
    assign w_hdr_p3    = {1'b0, w_hdr_clip} + 33'd3;
    assign w_rd_n      = WCW'(w_hdr_p3[32:2]);
    assign w_rd_zero   = (w_rd_n == '0);
    assign w_rd_last   = (r_rd_left == WCW'(1));
    assign w_head_p1   = f_wrap(SW'(r_head) + SW'(1));
    assign w_rd_pos_p1 = f_wrap(SW'(r_rd_pos) + SW'(1));

    assign w_rd_en   = i_cmd.rd_start || (i_cmd.rd_hdr && !w_rd_zero) ||
                       (i_cmd.rd_next && !w_rd_last);
    assign w_rd_addr = i_cmd.rd_start ? r_head : (i_cmd.rd_hdr ? w_head_p1 : w_rd_pos_p1);

    assign w_free_sum = FSW'(r_free) + FSW'(w_rd_n) + FSW'(1);
    assign w_free_rd  = (w_free_sum > FSW'(RING_WORDS)) ? FW'(RING_WORDS) : w_free_sum[FW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_addr] <= w_mem_wdata;
        if (w_rd_en)  r_rdata <= r_mem[w_rd_addr];
    end

    // Queue state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_free   <= FW'(RING_WORDS);
            r_count  <= '0;
            r_active <= 1'b0;
            r_max    <= C_MAX_BYTES_RESET;
        end else begin
            if (i_cfg_we) r_max <= i_cfg_data;
            if (i_cmd.deact) begin
                r_head   <= '0;
                r_tail   <= '0;
                r_free   <= FW'(RING_WORDS);
                r_count  <= '0;
                r_active <= 1'b0;
            end else begin
                if (i_cmd.wr_commit) begin
                    r_tail   <= f_wrap(SW'(r_tail) + SW'(w_eff_words) + SW'(1));
                    r_free   <= r_free - FW'(w_eff_words) - FW'(1);
                    r_count  <= r_count + FW'(1);
                    r_active <= 1'b1;
                end
                if (i_cmd.set_active) r_active <= 1'b1;
                if (i_cmd.rd_hdr) begin
                    r_head  <= f_wrap(SW'(r_head) + SW'(w_rd_n) + SW'(1));
                    r_free  <= w_free_rd;
                    r_count <= r_count - FW'(1);
                end
            end
        end
    end

    // Open write run and read sequence.
    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start) begin
            r_run_words <= w_words_now;
            r_hdr_addr  <= r_tail;
            r_hdr_bytes <= i_item.message_bytes;
        end
        if (w_data_we) begin
            r_wr_idx <= f_wrap(SW'(w_wr_base) + SW'(1));
            r_seen   <= w_seen_base + WCW'(1);
        end else if (i_cmd.run_start) begin
            r_wr_idx <= w_wr_base;
            r_seen   <= '0;
        end
        if (i_cmd.rd_hdr) begin
            r_rd_pos   <= w_head_p1;
            r_rd_left  <= w_rd_n;
            r_rd_bytes <= w_hdr_clip[6:0];
        end else if (i_cmd.rd_next) begin
            r_rd_pos  <= w_rd_pos_p1;
            r_rd_left <= r_rd_left - WCW'(1);
        end
        if (i_cmd.res_load) begin
            if (i_cmd.res_data) begin
                r_res.status      <= ST_OK;
                r_res.read_word   <= r_rdata;
                r_res.read_bytes  <= r_rd_bytes;
                r_res.last_result <= w_rd_last;
            end else begin
                r_res.status      <= i_cmd.res_status;
                r_res.read_word   <= '0;
                r_res.read_bytes  <= '0;
                r_res.last_result <= 1'b1;
            end
        end
    end

    assign o_res           = r_res;
    assign o_stat.wr_check = w_wr_check;
    assign o_stat.active   = r_active;
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.rd_zero  = w_rd_zero;
    assign o_stat.rd_last  = w_rd_last;

endmodule

`default_nettype wire

// ===== hw/rtl/length_prefixed_message_ring_unit.sv =====
// Top level of the length-prefixed message ring: controller, datapath and ports.
//
//  Channel   Direction  Handshake                    Payload
//  item      in         i_item_valid / o_item_ready  i_item  (t_item)
//  result    out        o_res_valid / i_res_ready    o_res   (t_res)
//  config    in         i_cfg_valid / o_cfg_ready    i_cfg_data (max message bytes)
//
// An accepted run's first word is followed by a header-write state before the next item is
// taken, because the header word and the data word share the ring memory's single write port.
// A successful read fetches the header and decodes it in the header-read state, then delivers one
// data word per cycle through the registered read port while the result side takes them.
// Reset is synchronous and active low; the ring memory is not cleared and no clearing
// pass is run, so the block accepts transactions as soon as reset is released.
// A result waits in the output register; a new item transaction is taken only while that
// register is empty or being emptied, and the read sequence pauses while the result side stalls.
`default_nettype none

module length_prefixed_message_ring_unit import lpmr_pkg::*; #(
    parameter int RING_WORDS        = C_RING_WORDS,
    parameter int MAX_MESSAGE_WORDS = C_MAX_MESSAGE_WORDS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_item_valid,
    output logic       o_item_ready,
    input  t_item      i_item,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output t_res       o_res,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);

    t_cmd     w_cmd;
    t_dp_stat w_stat;

    // The length register can be written in any cycle.
    assign o_cfg_ready = 1'b1;

    // The controller owns sequencing, the phase of an open write run and the result valid.
    lpmr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item_valid),
        .o_item_ready (o_item_ready),
        .i_item       (i_item),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    // The datapath holds the ring, its pointers and counters, and the result payload.
    lpmr_datapath #(
        .RING_WORDS        (RING_WORDS),
        .MAX_MESSAGE_WORDS (MAX_MESSAGE_WORDS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/lpmr_checker.sv =====
// Port-level assertions for the message ring, bound to the top level.
`default_nettype none

module lpmr_checker import lpmr_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_item_ready,
    input logic o_res_valid,
    input logic i_res_ready,
    input t_res o_res
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("stalled result changed or was dropped");

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |-> !o_item_ready)
        else $error("item taken while the result register is blocked");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status != ST_OK) |->
            o_res.last_result && (o_res.read_word == 32'd0) && (o_res.read_bytes == 7'd0))
        else $error("error result carries data or is not final");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

endmodule

bind length_prefixed_message_ring_unit lpmr_checker u_lpmr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_item_ready (o_item_ready),
    .o_res_valid  (o_res_valid),
    .i_res_ready  (i_res_ready),
    .o_res        (o_res)
);

`default_nettype wire

// ===== tb/length_prefixed_message_ring_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the length-prefixed message ring unit, with its own ring predictor.

module length_prefixed_message_ring_unit_test;
    import lpmr_pkg::*;

    // The operation code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int MAX_MSG_BYTES  = C_MAX_MESSAGE_WORDS * 4;
    localparam int RING_BYTES     = C_RING_WORDS * 4;
    // Cycles allowed after the last due result so that a run with no result can finish.
    localparam int SETTLE_CYCLES  = 12;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT    = 400000;

    // Every input starts at a known value; reset is held low from time zero.
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_item_valid = 1'b0;
    t_item      i_item       = '0;
    logic       i_res_ready  = 1'b0;
    logic       i_cfg_valid  = 1'b0;
    logic [6:0] i_cfg_data   = '0;
    logic       o_item_ready;
    logic       o_res_valid;
    t_res       o_res;
    logic       o_cfg_ready;

    length_prefixed_message_ring_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(i_item_valid),
        .o_item_ready(o_item_ready),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the ring, its pointers and the
    // open write run. m_written tracks which entries hold defined data, so
    // that the stimulus never ends a run early over an unwritten entry.
    // ------------------------------------------------------------------
    logic [31:0] m_mem [C_RING_WORDS];
    bit          m_written [C_RING_WORDS];
    int          m_head;
    int          m_tail;
    int          m_free;
    int          m_count;
    bit          m_active;
    int          m_wr_ptr;
    int          m_seen;
    int          m_len;
    t_run_phase  m_phase;
    int          m_max_bytes;

    // Results that the block owes us, oldest first.
    t_res ring_results_due [$];

    int items_sent;
    int results_seen;
    int mismatches;
    int cycle_count;
    int status_seen [5];

    // Idling percentages of each side, and requests for a long receiver hold-off.
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int holds_taken;
    int rx_hold_left;

    function automatic int words_for(int bytes);
        return (bytes + 3) / 4;
    endfunction

    function automatic t_item mk_item(logic [1:0] op, int bytes, logic [31:0] data,
                                      bit last, bit lock);
        t_item it;
        it.operation     = op;
        it.message_bytes = 8'(bytes);
        it.data_word     = data;
        it.last_word     = last;
        it.lock_denied   = lock;
        return it;
    endfunction

    task automatic due_result(t_status st, logic [31:0] word, int bytes, bit last);
        t_res r;
        r.status      = st;
        r.read_word   = word;
        r.read_bytes  = 7'(bytes);
        r.last_result = last;
        ring_results_due.push_back(r);
    endtask

    // Applies one accepted item transaction to the predictor and queues what it must produce.
    task automatic predict_ring_op(t_item it);
        int      lim;
        int      n;
        int      pos;
        int      rd_bytes;
        int      i;
        bit      run_open;
        t_status st;
        case (it.operation)
            OP_WRITE: begin
                if (m_phase == RUN_DISCARD) begin
                    // The remainder of a rejected run is swallowed silently.
                    if (it.last_word) m_phase = RUN_IDLE;
                end else begin
                    run_open = 1'b1;
                    if (m_phase != RUN_WRITING) begin
                        // First word of a run: the length check wins over the lock,
                        // which wins over the room check.
                        lim = (m_max_bytes > MAX_MSG_BYTES) ? MAX_MSG_BYTES : m_max_bytes;
                        st  = ST_OK;
                        if (int'(it.message_bytes) > lim) begin
                            st = ST_TOO_LONG;
                        end else if (it.lock_denied) begin
                            st = ST_LOCK;
                        end else if (4 + 4 * words_for(it.message_bytes) > m_free) begin
                            st       = ST_NO_ROOM;
                            m_active = 1'b1;
                        end
                        if (st != ST_OK) begin
                            due_result(st, '0, 0, 1'b1);
                            m_phase  = it.last_word ? RUN_IDLE : RUN_DISCARD;
                            run_open = 1'b0;
                        end else begin
                            m_mem[m_tail]     = 32'(it.message_bytes);
                            m_written[m_tail] = 1'b1;
                            m_wr_ptr = (m_tail + 1) % C_RING_WORDS;
                            m_seen   = 0;
                            m_len    = it.message_bytes;
                            m_phase  = RUN_WRITING;
                        end
                    end
                    if (run_open) begin
                        // Words beyond the rounded length are dropped.
                        if (m_seen < words_for(m_len)) begin
                            m_mem[m_wr_ptr]     = it.data_word;
                            m_written[m_wr_ptr] = 1'b1;
                            m_wr_ptr = (m_wr_ptr + 1) % C_RING_WORDS;
                            m_seen++;
                        end
                        if (it.last_word) begin
                            m_tail   = (m_tail + 1 + words_for(m_len)) % C_RING_WORDS;
                            m_free  -= 4 + 4 * words_for(m_len);
                            m_count++;
                            m_active = 1'b1;
                            m_phase  = RUN_IDLE;
                            due_result(ST_OK, '0, 0, 1'b1);
                        end
                    end
                end
            end
            OP_READ: begin
                // A read drops any open run without committing it.
                m_phase = RUN_IDLE;
                if (it.lock_denied) begin
                    due_result(ST_LOCK, '0, 0, 1'b1);
                end else if (!m_active) begin
                    due_result(ST_INACTIVE, '0, 0, 1'b1);
                end else if (m_count == 0) begin
                    due_result(ST_NO_ROOM, '0, 0, 1'b1);
                end else begin
                    rd_bytes = int'(m_mem[m_head]);
                    if (rd_bytes > MAX_MSG_BYTES) rd_bytes = MAX_MSG_BYTES;
                    n   = words_for(rd_bytes);
                    pos = (m_head + 1) % C_RING_WORDS;
                    if (n == 0) begin
                        due_result(ST_OK, '0, 0, 1'b1);
                    end else begin
                        for (i = 0; i < n; i++) begin
                            due_result(ST_OK, m_mem[pos], rd_bytes, i == n - 1);
                            pos = (pos + 1) % C_RING_WORDS;
                        end
                    end
                    m_head  = (m_head + 1 + n) % C_RING_WORDS;
                    m_free += 4 + 4 * n;
                    if (m_free > RING_BYTES) m_free = RING_BYTES;
                    m_count--;
                end
            end
            OP_DEACT: begin
                m_phase = RUN_IDLE;
                if (it.lock_denied) begin
                    due_result(ST_LOCK, '0, 0, 1'b1);
                end else begin
                    m_active = 1'b0;
                    m_free   = RING_BYTES;
                    m_head   = 0;
                    m_tail   = 0;
                    m_count  = 0;
                    due_result(ST_OK, '0, 0, 1'b1);
                end
            end
            default: begin
                // The unused operation gives nothing and leaves an open run alone.
            end
        endcase
    endtask

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: every result transaction is compared field by field
    // with the oldest result still due.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            results_seen++;
            if (o_res.status <= ST_LOCK) status_seen[int'(o_res.status)]++;
            if (ring_results_due.size() == 0) begin
                report_mismatch($sformatf("result with none due, status %0d word %h",
                                          o_res.status, o_res.read_word));
            end else begin
                want = ring_results_due.pop_front();
                if (o_res.status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %s",
                                              o_res.status, want.status.name()));
                if (o_res.read_word !== want.read_word)
                    report_mismatch($sformatf("read_word %h, wanted %h",
                                              o_res.read_word, want.read_word));
                if (o_res.read_bytes !== want.read_bytes)
                    report_mismatch($sformatf("read_bytes %0d, wanted %0d",
                                              o_res.read_bytes, want.read_bytes));
                if (o_res.last_result !== want.last_result)
                    report_mismatch($sformatf("last_result %b, wanted %b",
                                              o_res.last_result, want.last_result));
            end
        end
    end

    // Receiver: random stalls, or a long hold-off once one has been requested.
    always @(posedge i_clk) begin
        if (holds_taken != hold_requests) begin
            holds_taken  = hold_requests;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles, %0d results still due",
                     cycle_count, ring_results_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // Offers one item transaction after a random gap and predicts it once accepted.
    // Valid stays high between back-to-back items, so this task only lowers it for a gap.
    task automatic send_item(t_item it);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_item_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item_valid <= 1'b1;
        i_item       <= it;
        do @(posedge i_clk); while (!o_item_ready);
        items_sent++;
        predict_ring_op(it);
    endtask

    // Sends a run of write words with random data; the lock flag on later words must be ignored.
    task automatic send_message(int bytes, int n_words, bit end_run, bit lock);
        int i;
        for (i = 0; i < n_words; i++)
            send_item(mk_item(OP_WRITE, bytes, $urandom(), end_run && (i == n_words - 1),
                              (i == 0) ? lock : ($urandom_range(3) == 0)));
    endtask

    // The sender stops until every due result has arrived, then lets a run that
    // gives no result settle inside the block.
    task automatic wait_all_results;
        i_item_valid <= 1'b0;
        while (ring_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the maximum message length register with the block idle.
    task automatic set_max_bytes(int value);
        wait_all_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= 7'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        m_max_bytes = value;
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every operation, the status codes and the corner cases of a write run.
    task automatic test_basic_operations;
        send_item(mk_item(OP_READ, 0, '0, 1'b1, 1'b0));          // inactive queue
        send_item(mk_item(OP_READ, 0, '0, 1'b1, 1'b1));          // lock denied on read
        send_item(mk_item(OP_DEACT, 0, '0, 1'b1, 1'b1));         // lock denied on deactivate
        send_item(mk_item(OP_UNUSED, 255, '1, 1'b1, 1'b1));      // ignored, no result
        send_item(mk_item(OP_WRITE, 255, '1, 1'b1, 1'b1));       // too long beats the lock
        send_item(mk_item(OP_WRITE, 5, '0, 1'b1, 1'b1));         // lock denied on write
        send_item(mk_item(OP_READ, 0, '0, 1'b1, 1'b0));          // a refused write leaves it inactive
        send_item(mk_item(OP_WRITE, 0, '1, 1'b1, 1'b0));         // zero-length message
        send_item(mk_item(OP_READ, 0, '0, 1'b1, 1'b0));          // reads back as one empty word
        send_item(mk_item(OP_READ, 0, '0, 1'b1, 1'b0));          // active but empty
        send_item(mk_item(OP_WRITE, 5, '1, 1'b0, 1'b0));
        send_item(mk_item(OP_WRITE, 5, '0, 1'b1, 1'b0));
        // A read in the middle of a run drops the run and returns the older message.
        send_item(mk_item(OP_WRITE, 3, 32'hA5A5_A5A5, 1'b0, 1'b0));
        send_item(mk_item(OP_READ, 0, '0, 1'b1, 1'b0));
        // A word past the rounded length is not stored; mid-run fields are ignored.
        send_item(mk_item(OP_WRITE, 4, 32'h1234_5678, 1'b0, 1'b0));
        send_item(mk_item(OP_WRITE, 255, 32'hDEAD_BEEF, 1'b1, 1'b1));
        send_item(mk_item(OP_READ, 0, '0, 1'b1, 1'b0));
        // The unused operation inside a run leaves it open.
        send_item(mk_item(OP_WRITE, 8, 32'h0F0F_0F0F, 1'b0, 1'b0));
        send_item(mk_item(OP_UNUSED, 0, '0, 1'b0, 1'b0));
        send_item(mk_item(OP_WRITE, 8, 32'hF0F0_F0F0, 1'b1, 1'b0));
        send_item(mk_item(OP_READ, 0, '0, 1'b1, 1'b0));
        send_item(mk_item(OP_DEACT, 0, '0, 1'b1, 1'b0));
        send_item(mk_item(OP_READ, 0, '0, 1'b1, 1'b0));
        // A rejected run swallows its remaining words.
        send_item(mk_item(OP_WRITE, 65, '0, 1'b0, 1'b0));
        send_item(mk_item(OP_WRITE, 65, '1, 1'b1, 1'b0));
        send_item(mk_item(OP_READ, 0, '0, 1'b1, 1'b0));
    endtask

    // The length limit at several settings, from zero to a value above the saturation point.
    task automatic test_length_limit;
        int settings [5] = '{0, 1, 37, 127, MAX_MSG_BYTES};
        int eff;
        int i;
        for (i = 0; i < 5; i++) begin
            set_max_bytes(settings[i]);
            eff = (settings[i] > MAX_MSG_BYTES) ? MAX_MSG_BYTES : settings[i];
            send_message(eff, (eff == 0) ? 1 : words_for(eff), 1'b1, 1'b0);
            send_message(eff + 1, 1, 1'b1, 1'b0);
            send_item(mk_item(OP_READ, 0, '0, 1'b1, 1'b0));
        end
    endtask

    // Fills the ring while the receiver holds off, so that the block stalls its input,
    // until a write is refused for lack of room; then reads everything back.
    task automatic test_ring_fill;
        int  bytes;
        bit  ring_full;
        hold_requests++;
        ring_full = 1'b0;
        while (!ring_full) begin
            bytes = $urandom_range(40, MAX_MSG_BYTES);
            if (4 + 4 * words_for(bytes) > m_free) ring_full = 1'b1;
            send_message(bytes, words_for(bytes), 1'b1, 1'b0);
        end
        wait_all_results();
        while (m_count > 0) send_item(mk_item(OP_READ, 0, '0, 1'b1, 1'b0));
        wait_all_results();
    endtask

    // One random write run: mostly well formed, sometimes too long, locked,
    // over-long, cut short, or broken off by a read or a deactivate.
    task automatic random_message;
        int  lim;
        int  bytes;
        int  n;
        int  len;
        int  cut;
        int  k;
        int  i;
        bit  lock;
        bit  cut_ok;
        lim = (m_max_bytes > MAX_MSG_BYTES) ? MAX_MSG_BYTES : m_max_bytes;
        k   = $urandom_range(99);
        if (k < 8) bytes = $urandom_range(255);
        else if (k < 14) bytes = lim;
        else bytes = $urandom_range(lim);
        n    = words_for(bytes);
        len  = (n == 0) ? 1 : n;
        lock = ($urandom_range(99) < 5);
        k    = $urandom_range(99);
        if (k < 10) begin
            send_message(bytes, len + $urandom_range(1, 2), 1'b1, lock);
        end else if (k < 20 && n > 1) begin
            // Ending early is only allowed where the skipped entries already hold data.
            cut    = $urandom_range(1, n - 1);
            cut_ok = 1'b1;
            for (i = cut; i < n; i++)
                if (!m_written[(m_tail + 1 + i) % C_RING_WORDS]) cut_ok = 1'b0;
            send_message(bytes, cut_ok ? cut : len, 1'b1, lock);
        end else if (k < 26) begin
            send_message(bytes, $urandom_range(1, len), 1'b0, lock);
            send_item(mk_item(($urandom_range(3) == 0) ? OP_DEACT : OP_READ,
                              $urandom_range(255), $urandom(), 1'b1, 1'b0));
        end else begin
            send_message(bytes, len, 1'b1, lock);
        end
    endtask

    task automatic random_burst(int n_items);
        int target;
        int k;
        target = items_sent + n_items;
        while (items_sent < target) begin
            k = $urandom_range(99);
            if (k < 50)
                random_message();
            else if (k < 92)
                send_item(mk_item(OP_READ, $urandom_range(255), $urandom(),
                                  $urandom_range(1), $urandom_range(99) < 5));
            else if (k < 95)
                send_item(mk_item(OP_DEACT, $urandom_range(255), $urandom(),
                                  $urandom_range(1), $urandom_range(99) < 30));
            else
                send_item(mk_item(OP_UNUSED, $urandom_range(255), $urandom(),
                                  $urandom_range(1), $urandom_range(1)));
        end
    endtask

    // Random traffic in three idling regimes, with a fresh length limit for each.
    task automatic test_random_traffic;
        int tx_pct [3] = '{13, 86, 0};
        int rx_pct [3] = '{86, 13, 0};
        int ph;
        for (ph = 0; ph < 3; ph++) begin
            set_max_bytes((ph == 1) ? $urandom_range(4, MAX_MSG_BYTES) : MAX_MSG_BYTES);
            tx_idle_pct = tx_pct[ph];
            rx_idle_pct = rx_pct[ph];
            random_burst(20);
        end
    endtask

    initial begin
        m_head      = 0;
        m_tail      = 0;
        m_free      = RING_BYTES;
        m_count     = 0;
        m_active    = 1'b0;
        m_wr_ptr    = 0;
        m_seen      = 0;
        m_len       = 0;
        m_phase     = RUN_IDLE;
        m_max_bytes = int'(C_MAX_BYTES_RESET);
        tx_idle_pct = 13;
        rx_idle_pct = 86;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_operations();
        test_length_limit();
        test_ring_fill();
        test_random_traffic();
        wait_all_results();

        $display("Ran %0d item and %0d result transactions across limits 0 to 127,",
                 items_sent, results_seen);
        $display("a full ring, wrap-around and three idling regimes: ok %0d, too long %0d,",
                 status_seen[0], status_seen[1]);
        $display("no room %0d, inactive %0d, lock %0d",
                 status_seen[2], status_seen[3], status_seen[4]);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
